// ===== rtl/core/pearson_hash_stream_macros.svh =====
`ifndef PEARSON_HASH_STREAM_MACROS_SVH
`define PEARSON_HASH_STREAM_MACROS_SVH

// Assertion checked only while out of reset.
`define PHS_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Assertion checked on every edge, reset included.
`define PHS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/phs_pkg.sv =====
package phs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned HashW = 16;

  typedef struct packed {
    logic [ByteW-1:0] main;
    logic [ByteW-1:0] second;
  } chains_t;

  localparam logic [ByteW-1:0] PermRom [256] = '{
    8'd1,   8'd87,  8'd49,  8'd12,  8'd176, 8'd178, 8'd102, 8'd166,
    8'd121, 8'd193, 8'd6,   8'd84,  8'd249, 8'd230, 8'd44,  8'd163,
    8'd14,  8'd197, 8'd213, 8'd181, 8'd161, 8'd85,  8'd218, 8'd80,
    8'd64,  8'd239, 8'd24,  8'd226, 8'd236, 8'd142, 8'd38,  8'd200,
    8'd110, 8'd177, 8'd104, 8'd103, 8'd141, 8'd253, 8'd255, 8'd50,
    8'd77,  8'd101, 8'd81,  8'd18,  8'd45,  8'd96,  8'd31,  8'd222,
    8'd25,  8'd107, 8'd190, 8'd70,  8'd86,  8'd237, 8'd240, 8'd34,
    8'd72,  8'd242, 8'd20,  8'd214, 8'd244, 8'd227, 8'd149, 8'd235,
    8'd97,  8'd234, 8'd57,  8'd22,  8'd60,  8'd250, 8'd82,  8'd175,
    8'd208, 8'd5,   8'd127, 8'd199, 8'd111, 8'd62,  8'd135, 8'd248,
    8'd174, 8'd169, 8'd211, 8'd58,  8'd66,  8'd154, 8'd106, 8'd195,
    8'd245, 8'd171, 8'd17,  8'd187, 8'd182, 8'd179, 8'd0,   8'd243,
    8'd132, 8'd56,  8'd148, 8'd75,  8'd128, 8'd133, 8'd158, 8'd100,
    8'd130, 8'd126, 8'd91,  8'd13,  8'd153, 8'd246, 8'd216, 8'd219,
    8'd119, 8'd68,  8'd223, 8'd78,  8'd83,  8'd88,  8'd201, 8'd99,
    8'd122, 8'd11,  8'd92,  8'd32,  8'd136, 8'd114, 8'd52,  8'd10,
    8'd138, 8'd30,  8'd48,  8'd183, 8'd156, 8'd35,  8'd61,  8'd26,
    8'd143, 8'd74,  8'd251, 8'd94,  8'd129, 8'd162, 8'd63,  8'd152,
    8'd170, 8'd7,   8'd115, 8'd167, 8'd241, 8'd206, 8'd3,   8'd150,
    8'd55,  8'd59,  8'd151, 8'd220, 8'd90,  8'd53,  8'd23,  8'd131,
    8'd125, 8'd173, 8'd15,  8'd238, 8'd79,  8'd95,  8'd89,  8'd16,
    8'd105, 8'd137, 8'd225, 8'd224, 8'd217, 8'd160, 8'd37,  8'd123,
    8'd118, 8'd73,  8'd2,   8'd157, 8'd46,  8'd116, 8'd9,   8'd145,
    8'd134, 8'd228, 8'd207, 8'd212, 8'd202, 8'd215, 8'd69,  8'd229,
    8'd27,  8'd188, 8'd67,  8'd124, 8'd168, 8'd252, 8'd42,  8'd4,
    8'd29,  8'd108, 8'd21,  8'd247, 8'd19,  8'd205, 8'd39,  8'd203,
    8'd233, 8'd40,  8'd186, 8'd147, 8'd198, 8'd192, 8'd155, 8'd33,
    8'd164, 8'd191, 8'd98,  8'd204, 8'd165, 8'd180, 8'd117, 8'd76,
    8'd140, 8'd36,  8'd210, 8'd172, 8'd41,  8'd54,  8'd159, 8'd8,
    8'd185, 8'd232, 8'd113, 8'd196, 8'd231, 8'd47,  8'd146, 8'd120,
    8'd51,  8'd65,  8'd28,  8'd144, 8'd254, 8'd221, 8'd93,  8'd189,
    8'd194, 8'd139, 8'd112, 8'd43,  8'd71,  8'd109, 8'd184, 8'd209
  };

  function automatic logic [ByteW-1:0] perm_lookup(input logic [ByteW-1:0] idx);
    return PermRom[idx];
  endfunction

endpackage

// ===== rtl/core/phs_round.sv =====
module phs_round (
  input  logic                           first_i,
  input  logic [phs_pkg::ByteW-1:0]      byte_i,
  input  phs_pkg::chains_t               chains_i,
  output phs_pkg::chains_t               chains_o
);

  always_comb begin
    if (first_i) begin
      chains_o.main   = phs_pkg::perm_lookup(byte_i);
      chains_o.second = phs_pkg::perm_lookup(byte_i + phs_pkg::ByteW'(1));
    end else begin
      chains_o.main   = phs_pkg::perm_lookup(chains_i.main ^ byte_i);
      chains_o.second = phs_pkg::perm_lookup(chains_i.second ^ byte_i);
    end
  end

endmodule

// ===== rtl/core/pearson_hash_stream.sv =====
// Pearson byte-stream hash, 8-bit or 16-bit result.
// Input stream: one message byte per transfer on s_axis_tdata, s_axis_tlast
// set on the final byte. Every message has at least one byte.
// Output stream: one hash per message on m_axis_tdata. In narrow mode the
// upper byte is zero; in wide mode the main chain sits in the upper byte and
// the second chain in the lower byte.
// Config: cfg_data_i selects wide mode on a cfg_valid_i transfer; cfg_ready_o
// is always high. Write it only while no message is in flight.
// Throughput: one byte per cycle, except that a last byte waits while the
// hash is stalled; the chain update (two ROM lookups and an XOR) sits between
// the input register and the chain/result registers. A last byte is held in
// the input register, then its hash is registered in the result register.
// When the receiver stalls, the hash holds in the result register; bytes that
// are not last keep flowing, and a last byte waits in the input register with
// s_axis_tready low until the result register frees up.
// Reset: narrow mode, chains cleared, next byte starts a new message, both
// streams empty.
module pearson_hash_stream (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [phs_pkg::ByteW-1:0]     s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // last_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [phs_pkg::HashW-1:0]     m_axis_tdata,  // [15:0] hash_value
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);

  logic                        in_valid_q, in_valid_d;
  logic [phs_pkg::ByteW-1:0]   in_byte_q;
  logic                        in_last_q;
  logic                        out_valid_q, out_valid_d;
  logic [phs_pkg::HashW-1:0]   hash_q, hash_d;
  logic                        wide_q;
  logic                        first_q, first_d;
  phs_pkg::chains_t            chains_q, chains_d, chains_nxt;
  logic                        s_xfer;
  logic                        out_free;
  logic                        step_fire;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign step_fire   = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || step_fire;
  assign s_xfer      = s_axis_tvalid && s_axis_tready;

  phs_round u_round (
    .first_i  (first_q),
    .byte_i   (in_byte_q),
    .chains_i (chains_q),
    .chains_o (chains_nxt)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    hash_d      = hash_q;
    first_d     = first_q;
    chains_d    = chains_q;

    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    if (step_fire) begin
      if (in_last_q) begin
        out_valid_d = 1'b1;
        hash_d      = wide_q ? {chains_nxt.main, chains_nxt.second}
                             : {{phs_pkg::ByteW{1'b0}}, chains_nxt.main};
        first_d     = 1'b1;
        chains_d    = '0;
      end else begin
        first_d     = 1'b0;
        chains_d    = chains_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b1;
      chains_q    <= '0;
      wide_q      <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      first_q     <= first_d;
      chains_q    <= chains_d;
      if (cfg_valid_i) begin
        wide_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    hash_q <= hash_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = hash_q;

endmodule

// ===== rtl/core/phs_checker.sv =====
`include "pearson_hash_stream_macros.svh"

module phs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [phs_pkg::ByteW-1:0]     s_axis_tdata,
  input logic                          s_axis_tlast,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [phs_pkg::HashW-1:0]     m_axis_tdata,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic                          cfg_data_i
);

  logic unused_in;
  assign unused_in = ^{s_axis_tdata, cfg_valid_i, cfg_ready_o, cfg_data_i};

  `PHS_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

  `PHS_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled hash changed")

  // input backpressure only comes from a stalled result
  `PHS_ASSERT(a_stall_cause, clk_i, rst_ni, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

  // a fresh hash needs an earlier last-byte transfer
  `PHS_ASSERT(a_hash_source, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2), "hash without last byte")

endmodule

bind pearson_hash_stream phs_checker u_phs_checker (.*);
